>>> sv/ptmdgr_pkg.sv
// Shared widths, register indexes, reset values and types of the PTM diffuse gain relighter.
package ptmdgr_pkg;

    // Field and fixed point formats
    localparam int COEFF_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int GAIN_FRAC = 12;
    localparam int REG_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int CHAN_W    = 2;
    localparam int IDX_W     = 2;

    // Common scale of the accumulated value: 2^(gain frac + 2 * light frac)
    localparam int SCALE = GAIN_FRAC + 2 * FRAC_BITS;

    // Datapath widths
    localparam int D_W    = REG_W + 1;              // light minus normal
    localparam int SQD_W  = 2 * D_W;                // products of differences
    localparam int SQL_W  = 2 * REG_W;              // products of light terms
    localparam int TD_W   = COEFF_W + SQD_W;
    localparam int TL_W   = COEFF_W + SQL_W;
    localparam int QD_W   = TD_W + 2;               // quadratic form at l - n
    localparam int QL_W   = TL_W + 2;               // quadratic form at l
    localparam int LIN_W  = COEFF_W + REG_W + 1;    // a3*lu + a4*lv
    localparam int GM_W   = REG_W + 1;              // gain minus one
    localparam int QLO_W  = QD_W / 2;
    localparam int QHI_W  = QD_W - QLO_W;
    localparam int PL_W   = GM_W + QLO_W + 1;
    localparam int PH_W   = GM_W + QHI_W;
    localparam int ACC_W  = GM_W + QD_W + 2;
    localparam int LUM_W  = SCALE + 2 * BYTE_W;     // value below 65536, all fraction bits
    localparam int PROD_W = LUM_W + BYTE_W;

    localparam logic signed [GM_W-1:0] GAIN_ONE = GM_W'(1 << GAIN_FRAC);
    localparam logic [BYTE_W-1:0]      BYTE_MAX = '1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN    = 2'd1;
    localparam logic [IDX_W-1:0] REG_LIGHT_U = 2'd2;
    localparam logic [IDX_W-1:0] REG_LIGHT_V = 2'd3;

    // Reset values
    localparam logic             MODE_RST  = 1'b0;
    localparam logic [REG_W-1:0] GAIN_RST  = 16'd8192;
    localparam logic [REG_W-1:0] LIGHT_RST = 16'd0;

    // Channel codes
    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

    // Colour bytes and channel index carried alongside the arithmetic
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [CHAN_W-1:0] chan;
    } t_side;

endpackage

>>> sv/ptm_diffuse_gain_relight.sv
// Top level: pipelined PTM diffuse gain relighting with a byte serialiser on the result side.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------------------
//  input     in         i_valid / o_ready         i_coef_a0..a5, i_normal_u/v, RGB, channel
//  result    out        o_valid / i_ready         o_pixel_value, o_out_channel, o_last_of_item
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Six arithmetic stages, a holding stage and the output register. A word enters every
// cycle when the pipe flows. The single result port sets the rate: it sends three bytes
// a word in luminance mode and one byte a word in RGB mode.
// Reset (synchronous, active low) empties every stage and loads the register defaults.
// A stall on i_ready freezes the output register and backs up stage by stage; each
// stage still takes a new word when it is empty, so bubbles are squeezed out.
module ptm_diffuse_gain_relight
    import ptmdgr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input words
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COEFF_W-1:0] i_coef_a0,
    input  logic signed [COEFF_W-1:0] i_coef_a1,
    input  logic signed [COEFF_W-1:0] i_coef_a2,
    input  logic signed [COEFF_W-1:0] i_coef_a3,
    input  logic signed [COEFF_W-1:0] i_coef_a4,
    input  logic signed [COEFF_W-1:0] i_coef_a5,
    input  logic signed [REG_W-1:0]   i_normal_u,
    input  logic signed [REG_W-1:0]   i_normal_v,
    input  logic [BYTE_W-1:0]         i_red_byte,
    input  logic [BYTE_W-1:0]         i_green_byte,
    input  logic [BYTE_W-1:0]         i_blue_byte,
    input  logic [CHAN_W-1:0]         i_channel_index,
    // result words
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [BYTE_W-1:0]         o_pixel_value,
    output logic [CHAN_W-1:0]         o_out_channel,
    output logic                      o_last_of_item,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [REG_W-1:0]          i_cfg_data
);

    // ---------------------------------------------------------------- registers
    logic                    r_mode;
    logic [REG_W-1:0]        r_gain_q12;
    logic signed [REG_W-1:0] r_light_u;
    logic signed [REG_W-1:0] r_light_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RST;
            r_gain_q12 <= GAIN_RST;
            r_light_u  <= LIGHT_RST;
            r_light_v  <= LIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:    r_mode     <= i_cfg_data[0];
                REG_GAIN:    r_gain_q12 <= i_cfg_data;
                REG_LIGHT_U: r_light_u  <= i_cfg_data;
                REG_LIGHT_V: r_light_v  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // gain minus one, signed Q5.12
    logic signed [GM_W-1:0] gm;
    assign gm = $signed({1'b0, r_gain_q12}) - GAIN_ONE;

    // ---------------------------------------------------------------- flow control
    // w_en[k]: stage k may load this cycle; stage 7 is the holding stage.
    logic [7:1] w_en;
    logic [6:1] r_v;
    logic       r_h_v;
    logic       r_o_v;
    logic       out_free;
    logic       load_o;
    logic       h_last;

    assign out_free = !r_o_v || i_ready;
    assign load_o   = r_h_v && out_free;
    assign w_en[7]  = !r_h_v || (load_o && h_last);
    assign w_en[6]  = !r_v[6] || w_en[7];
    assign w_en[5]  = !r_v[5] || w_en[6];
    assign w_en[4]  = !r_v[4] || w_en[5];
    assign w_en[3]  = !r_v[3] || w_en[4];
    assign w_en[2]  = !r_v[2] || w_en[3];
    assign w_en[1]  = !r_v[1] || w_en[2];
    assign o_ready  = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_h_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_en[1]) r_v[1] <= i_valid;
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
            if (w_en[5]) r_v[5] <= r_v[4];
            if (w_en[6]) r_v[6] <= r_v[5];
            if (w_en[7]) r_h_v  <= r_v[6];
            if (out_free) r_o_v <= r_h_v;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Latch the word and form the light-minus-normal differences.
    logic signed [COEFF_W-1:0] r1_a0, r1_a1, r1_a2, r1_a3, r1_a4, r1_a5;
    logic signed [D_W-1:0]     r1_du, r1_dv;
    t_side                     r1_side;
    logic signed [D_W-1:0]     n1_du, n1_dv;

    assign n1_du = D_W'(r_light_u) - D_W'(i_normal_u);
    assign n1_dv = D_W'(r_light_v) - D_W'(i_normal_v);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_a0   <= i_coef_a0;
            r1_a1   <= i_coef_a1;
            r1_a2   <= i_coef_a2;
            r1_a3   <= i_coef_a3;
            r1_a4   <= i_coef_a4;
            r1_a5   <= i_coef_a5;
            r1_du   <= n1_du;
            r1_dv   <= n1_dv;
            r1_side <= '{red: i_red_byte, green: i_green_byte, blue: i_blue_byte,
                         chan: i_channel_index};
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Second-order monomials of (l - n) and of l, and the linear term.
    logic signed [COEFF_W-1:0] r2_a0, r2_a1, r2_a2, r2_a5;
    logic signed [SQD_W-1:0]   r2_sq_du, r2_sq_dv, r2_duv;
    logic signed [SQL_W-1:0]   r2_sq_lu, r2_sq_lv, r2_luv;
    logic signed [LIN_W-1:0]   r2_lin;
    t_side                     r2_side;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_a0    <= r1_a0;
            r2_a1    <= r1_a1;
            r2_a2    <= r1_a2;
            r2_a5    <= r1_a5;
            r2_sq_du <= SQD_W'(r1_du) * SQD_W'(r1_du);
            r2_sq_dv <= SQD_W'(r1_dv) * SQD_W'(r1_dv);
            r2_duv   <= SQD_W'(r1_du) * SQD_W'(r1_dv);
            r2_sq_lu <= SQL_W'(r_light_u) * SQL_W'(r_light_u);
            r2_sq_lv <= SQL_W'(r_light_v) * SQL_W'(r_light_v);
            r2_luv   <= SQL_W'(r_light_u) * SQL_W'(r_light_v);
            r2_lin   <= LIN_W'(r1_a3) * LIN_W'(r_light_u)
                      + LIN_W'(r1_a4) * LIN_W'(r_light_v);
            r2_side  <= r1_side;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Coefficient times monomial.
    logic signed [TD_W-1:0]    r3_td0, r3_td1, r3_td2;
    logic signed [TL_W-1:0]    r3_tl0, r3_tl1, r3_tl2;
    logic signed [LIN_W-1:0]   r3_lin;
    logic signed [COEFF_W-1:0] r3_a5;
    t_side                     r3_side;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_td0  <= TD_W'(r2_a0) * TD_W'(r2_sq_du);
            r3_td1  <= TD_W'(r2_a1) * TD_W'(r2_sq_dv);
            r3_td2  <= TD_W'(r2_a2) * TD_W'(r2_duv);
            r3_tl0  <= TL_W'(r2_a0) * TL_W'(r2_sq_lu);
            r3_tl1  <= TL_W'(r2_a1) * TL_W'(r2_sq_lv);
            r3_tl2  <= TL_W'(r2_a2) * TL_W'(r2_luv);
            r3_lin  <= r2_lin;
            r3_a5   <= r2_a5;
            r3_side <= r2_side;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Quadratic forms Q(l - n) and Q(l).
    logic signed [QD_W-1:0]    r4_qd;
    logic signed [QL_W-1:0]    r4_ql;
    logic signed [LIN_W-1:0]   r4_lin;
    logic signed [COEFF_W-1:0] r4_a5;
    t_side                     r4_side;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_qd   <= QD_W'(r3_td0) + QD_W'(r3_td1) + QD_W'(r3_td2);
            r4_ql   <= QL_W'(r3_tl0) + QL_W'(r3_tl1) + QL_W'(r3_tl2);
            r4_lin  <= r3_lin;
            r4_a5   <= r3_a5;
            r4_side <= r3_side;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // (g - 1) * Q(l - n) as two partial products; the rest aligned to the common scale.
    logic signed [QLO_W:0]   qd_lo;
    logic signed [QHI_W-1:0] qd_hi;
    logic signed [PL_W-1:0]  r5_pl;
    logic signed [PH_W-1:0]  r5_ph;
    logic signed [ACC_W-1:0] r5_base;
    t_side                   r5_side;

    assign qd_lo = $signed({1'b0, r4_qd[QLO_W-1:0]});
    assign qd_hi = r4_qd[QD_W-1:QLO_W];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_pl   <= PL_W'(gm) * PL_W'(qd_lo);
            r5_ph   <= PH_W'(gm) * PH_W'(qd_hi);
            r5_base <= (ACC_W'(r4_ql) <<< GAIN_FRAC)
                     + (ACC_W'(r4_lin) <<< (GAIN_FRAC + FRAC_BITS))
                     + (ACC_W'(r4_a5) <<< SCALE);
            r5_side <= r4_side;
        end
    end

    // ---------------------------------------------------------------- stage 6
    // Exact value V * 2^SCALE.
    logic signed [ACC_W-1:0] r6_acc;
    t_side                   r6_side;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_acc  <= (ACC_W'(r5_ph) <<< QLO_W) + ACC_W'(r5_pl) + r5_base;
            r6_side <= r5_side;
        end
    end

    // ---------------------------------------------------------------- holding stage
    // Range flags of V, its integer byte and the bits needed for colour scaling.
    logic               r_h_neg;     // V < 0
    logic               r_h_big;     // V >= 65536: any nonzero colour saturates
    logic               r_h_ge256;   // V >= 256
    logic [BYTE_W-1:0]  r_h_int;     // floor(V) mod 256
    logic [LUM_W-1:0]   r_h_accl;
    t_side              r_h_side;
    logic [CHAN_W-1:0]  r_cnt;       // next channel to send in luminance mode

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_h_neg   <= r6_acc[ACC_W-1];
            r_h_big   <= |r6_acc[ACC_W-2:LUM_W];
            r_h_ge256 <= |r6_acc[ACC_W-2:SCALE+BYTE_W];
            r_h_int   <= r6_acc[SCALE+BYTE_W-1:SCALE];
            r_h_accl  <= r6_acc[LUM_W-1:0];
            r_h_side  <= r6_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CH_RED;
        end else if (load_o) begin
            r_cnt <= h_last ? CH_RED : r_cnt + 2'd1;
        end
    end

    assign h_last = r_mode || (r_cnt == CH_BLUE);

    // ---------------------------------------------------------------- byte forming
    logic [BYTE_W-1:0]   sel_b;
    logic [PROD_W-1:0]   lum_prod;
    logic [2*BYTE_W-1:0] lum_q;
    logic [BYTE_W-1:0]   lum_byte;
    logic [BYTE_W-1:0]   rgb_byte;

    always_comb begin
        unique case (r_cnt)
            CH_RED:   sel_b = r_h_side.red;
            CH_GREEN: sel_b = r_h_side.green;
            CH_BLUE:  sel_b = r_h_side.blue;
            default:  sel_b = '0;
        endcase
    end

    // floor(colour * V / 256), exact over all fraction bits
    assign lum_prod = PROD_W'(r_h_accl) * PROD_W'(sel_b);
    assign lum_q    = lum_prod[PROD_W-1:SCALE+BYTE_W];

    always_comb begin
        priority if (r_h_neg) begin
            lum_byte = '0;
        end else if (r_h_big) begin
            lum_byte = (sel_b != '0) ? BYTE_MAX : '0;
        end else if (lum_q[2*BYTE_W-1:BYTE_W] != '0) begin
            lum_byte = BYTE_MAX;
        end else begin
            lum_byte = lum_q[BYTE_W-1:0];
        end
    end

    always_comb begin
        priority if (r_h_neg) begin
            rgb_byte = '0;
        end else if (r_h_ge256) begin
            rgb_byte = BYTE_MAX;
        end else begin
            rgb_byte = r_h_int;
        end
    end

    // ---------------------------------------------------------------- output register
    logic [BYTE_W-1:0] r_o_value;
    logic [CHAN_W-1:0] r_o_chan;
    logic              r_o_last;

    always_ff @(posedge i_clk) begin
        if (load_o) begin
            r_o_value <= r_mode ? rgb_byte : lum_byte;
            r_o_chan  <= r_mode ? r_h_side.chan : r_cnt;
            r_o_last  <= h_last;
        end
    end

    assign o_valid        = r_o_v;
    assign o_pixel_value  = r_o_value;
    assign o_out_channel  = r_o_chan;
    assign o_last_of_item = r_o_last;

endmodule
